>>> hdl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`endif

>>> hdl/ptts_pkg.sv
// Shared types and constants of the periodic task tick scheduler.
// Depends on nothing; used by the interfaces and all scheduler modules.
package ptts_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_DISP  = 3'd2;
    localparam logic [2:0] CMD_DEL   = 3'd3;
    localparam logic [2:0] CMD_CLR   = 3'd4;

    // Result status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_NONE  = 2'd2;
    localparam logic [1:0] STS_BAD   = 2'd3;

    localparam int         DATA_W    = 32;
    localparam int         DISP_CAP  = 16;
    localparam int         CNT_W     = $clog2(DISP_CAP + 1);
    localparam logic [7:0] PEND_MAX  = 8'hFF;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [DATA_W-1:0] delay_ms;
        logic [DATA_W-1:0] period_ms;
        logic [7:0]        slot_index;
    } t_req;

    typedef struct packed {
        logic [3:0] slot;
        logic [1:0] status;
        logic       last;
    } t_rsp;

    // One slot table entry: delay and period in ticks, pend as due events not yet dispatched
    typedef struct packed {
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] period;
        logic [7:0]        pend;
    } t_entry;

endpackage

>>> hdl/ptts_if.sv
// Request and response channel interfaces of the scheduler.
// Depends on ptts_pkg for the payload types.
interface ptts_req_if;
    logic              valid;
    logic              ready;
    ptts_pkg::t_req    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptts_rsp_if;
    logic              valid;
    logic              ready;
    ptts_pkg::t_rsp    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ptts_mem.sv
// Slot table memory: one write port, one read port with registered data.
// Depends on ptts_pkg for the entry type.
module ptts_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  ptts_pkg::t_entry    i_wdata,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_raddr,
    output ptts_pkg::t_entry    o_rdata
);

    ptts_pkg::t_entry r_mem [DEPTH];
    ptts_pkg::t_entry r_rdata;

    // Write and read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ptts_div.sv
// Divide of the delay and period by the tick length: reciprocal multiply, then one fix-up.
// Registered steps after start: multiply, remainder, fix-up; depends on ptts_pkg for the data width.
module ptts_div #(
    parameter int DIVISOR = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ptts_pkg::DATA_W-1:0]   i_delay_ms,
    input  logic [ptts_pkg::DATA_W-1:0]   i_period_ms,
    output logic                          o_busy,
    output logic [ptts_pkg::DATA_W-1:0]   o_delay_q,
    output logic [ptts_pkg::DATA_W-1:0]   o_period_q
);

    localparam int DW  = ptts_pkg::DATA_W;
    localparam int DW2 = 2 * DW;
    localparam int RW  = $clog2(DIVISOR) + 1;
    // floor(2^DW / DIVISOR) kept to DW bits; the estimate is the quotient or one below
    localparam logic [DW2-1:0] RECIP_FULL = (DW2'(1) << DW) / DW2'(DIVISOR);
    localparam logic [DW-1:0]  RECIP      = (DIVISOR == 1) ? {DW{1'b1}} : RECIP_FULL[DW-1:0];
    localparam logic [DW-1:0]  DIV_K      = DW'(DIVISOR);
    localparam logic [RW-1:0]  DIV_R      = RW'(DIVISOR);

    localparam logic [1:0] STEP_MUL = 2'd0;
    localparam logic [1:0] STEP_REM = 2'd1;
    localparam logic [1:0] STEP_FIX = 2'd2;

    logic            r_busy;
    logic [1:0]      r_step;
    logic [DW-1:0]   r_xa;
    logic [DW-1:0]   r_xb;
    logic [DW-1:0]   r_qa;
    logic [DW-1:0]   r_qb;
    logic [RW-1:0]   r_ra;
    logic [RW-1:0]   r_rb;

    logic [DW2-1:0]  w_pa;
    logic [DW2-1:0]  w_pb;
    logic [DW-1:0]   w_da;
    logic [DW-1:0]   w_db;
    logic            w_ga;
    logic            w_gb;

    // Estimate by the reciprocal, remainder of the estimate, round up when it reaches the divisor
    assign w_pa = {{DW{1'b0}}, r_xa} * {{DW{1'b0}}, RECIP};
    assign w_pb = {{DW{1'b0}}, r_xb} * {{DW{1'b0}}, RECIP};
    assign w_da = r_xa - r_qa * DIV_K;
    assign w_db = r_xb - r_qb * DIV_K;
    assign w_ga = (r_ra >= DIV_R);
    assign w_gb = (r_rb >= DIV_R);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_MUL;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_MUL;
            r_xa   <= i_delay_ms;
            r_xb   <= i_period_ms;
        end else if (r_busy) begin
            case (r_step)
                STEP_MUL: begin
                    r_qa   <= w_pa[DW2-1:DW];
                    r_qb   <= w_pb[DW2-1:DW];
                    r_step <= STEP_REM;
                end
                STEP_REM: begin
                    r_ra   <= w_da[RW-1:0];
                    r_rb   <= w_db[RW-1:0];
                    r_step <= STEP_FIX;
                end
                STEP_FIX: begin
                    r_qa   <= r_qa + {{(DW-1){1'b0}}, w_ga};
                    r_qb   <= r_qb + {{(DW-1){1'b0}}, w_gb};
                    r_busy <= 1'b0;
                    r_step <= STEP_MUL;
                end
                default: begin
                    r_busy <= 1'b0;
                    r_step <= STEP_MUL;
                end
            endcase
        end
    end

    assign o_busy     = r_busy;
    assign o_delay_q  = r_qa;
    assign o_period_q = r_qb;

endmodule

>>> hdl/periodic_task_tick_scheduler_core.sv
// Channel   Dir  Handshake    Payload
// i_req     in   valid/ready  cmd, delay_ms, period_ms, slot_index
// o_rsp     out  valid/ready  slot, status, last
//
// Tick scans one slot a cycle; dispatch does too unless stalled, then flushes the last
// result. Add runs the 3-step divide and the lowest free slot search together, and the
// search covers every slot when the table is full. Delete flushes its result too; clear
// all and unknown commands complete in idle. Synchronous reset clears the used
// marks at once; table entries need no clearing. Stalls: flush waits for a free output
// register, as does a dispatch scan at a due slot while an earlier due slot is held.
module periodic_task_tick_scheduler_core #(
    parameter int MAX_SLOTS = 16,
    parameter int TICK_MS   = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ptts_req_if.sink     i_req,
    ptts_rsp_if.source   o_rsp
);

    `include "assert_macros.svh"

    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IW = $clog2(MAX_SLOTS + 1);
    localparam logic [IW-1:0] IDX_END = IW'(MAX_SLOTS);
    localparam logic [7:0]    SLOTS_B = 8'(MAX_SLOTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]                     r_state;
    logic [2:0]                     r_cmd;
    logic [MAX_SLOTS-1:0]           r_used;
    logic [IW-1:0]                  r_ridx;
    logic                           r_ev;
    logic [SW-1:0]                  r_eidx;
    logic [ptts_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_hold_v;
    logic [3:0]                     r_hold_slot;
    logic [1:0]                     r_hold_sts;
    logic                           r_out_v;
    ptts_pkg::t_rsp                 r_out;
    logic                           r_found;
    logic [SW-1:0]                  r_add_slot;

    logic                           w_acc;
    logic                           w_out_free;
    logic                           w_out_load;
    logic                           w_disp;
    logic                           w_hit;
    logic                           w_stall;
    logic                           w_issue;
    logic                           w_scan_end;
    logic                           w_add_done;
    logic                           w_rd_en;
    logic [SW-1:0]                  w_raddr;
    ptts_pkg::t_entry               w_rdata;
    logic                           w_we;
    logic [SW-1:0]                  w_waddr;
    ptts_pkg::t_entry               w_wdata;
    logic                           w_div_start;
    logic                           w_div_busy;
    logic [ptts_pkg::DATA_W-1:0]    w_q_delay;
    logic [ptts_pkg::DATA_W-1:0]    w_q_period;

    ptts_mem #(
        .DEPTH (MAX_SLOTS),
        .AW    (SW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_rd_en (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ptts_div #(
        .DIVISOR (TICK_MS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_delay_ms  (i_req.data.delay_ms),
        .i_period_ms (i_req.data.period_ms),
        .o_busy      (w_div_busy),
        .o_delay_q   (w_q_delay),
        .o_period_q  (w_q_period)
    );

    // Handshake and scan control
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_div_start = w_acc && (i_req.data.cmd == ptts_pkg::CMD_ADD);
    assign w_out_free  = !r_out_v || o_rsp.ready;
    assign w_disp      = (r_cmd == ptts_pkg::CMD_DISP);
    assign w_hit       = (r_state == ST_SCAN) && r_ev && r_used[r_eidx] && w_disp
                         && (w_rdata.pend != 8'd0) && (r_cnt < ptts_pkg::DISP_CAP);
    assign w_stall     = w_hit && r_hold_v && !w_out_free;
    assign w_issue     = (r_state == ST_SCAN) && (r_ridx != IDX_END) && !w_stall;
    assign w_rd_en     = w_issue;
    assign w_raddr     = r_ridx[SW-1:0];
    assign w_scan_end  = (r_state == ST_SCAN) && !r_ev && (r_ridx == IDX_END);
    assign w_add_done  = (r_state == ST_ADD) && !w_div_busy
                         && (r_found || (r_ridx == IDX_END));
    // Load the output register with a passed-on dispatch result or the final result
    assign w_out_load  = (w_hit && r_hold_v && !w_stall)
                         || ((r_state == ST_FLUSH) && w_out_free);

    // Update the entry last read, or store an added entry; the read runs one slot ahead
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_eidx;
        w_wdata = w_rdata;
        if ((r_state == ST_SCAN) && r_ev && r_used[r_eidx] && !w_stall) begin
            if (w_disp) begin
                if (w_hit) begin
                    w_we         = 1'b1;
                    w_wdata.pend = w_rdata.pend - 8'd1;
                end
            end else begin
                w_we = 1'b1;
                if (w_rdata.delay == '0) begin
                    if (w_rdata.pend != ptts_pkg::PEND_MAX) begin
                        w_wdata.pend = w_rdata.pend + 8'd1;
                    end
                    if (w_rdata.period != '0) begin
                        w_wdata.delay = w_rdata.period;
                    end
                end else begin
                    w_wdata.delay = w_rdata.delay - 1'b1;
                end
            end
        end else if (w_add_done && r_found) begin
            w_we           = 1'b1;
            w_waddr        = r_add_slot;
            w_wdata.delay  = w_q_delay;
            w_wdata.period = w_q_period;
            w_wdata.pend   = 8'd0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_ridx   <= '0;
            r_ev     <= 1'b0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_cmd    <= i_req.data.cmd;
                        r_ridx   <= '0;
                        r_ev     <= 1'b0;
                        r_cnt    <= '0;
                        r_hold_v <= 1'b0;
                        r_found  <= 1'b0;
                        case (i_req.data.cmd)
                            ptts_pkg::CMD_TICK, ptts_pkg::CMD_DISP: begin
                                r_state <= ST_SCAN;
                            end
                            ptts_pkg::CMD_ADD: begin
                                r_state <= ST_ADD;
                            end
                            ptts_pkg::CMD_DEL: begin
                                if (i_req.data.slot_index >= SLOTS_B) begin
                                    r_hold_slot <= 4'd0;
                                    r_hold_sts  <= ptts_pkg::STS_BAD;
                                end else begin
                                    r_used[i_req.data.slot_index[SW-1:0]] <= 1'b0;
                                    r_hold_slot <= i_req.data.slot_index[3:0];
                                    r_hold_sts  <= ptts_pkg::STS_OK;
                                end
                                r_state <= ST_FLUSH;
                            end
                            ptts_pkg::CMD_CLR: begin
                                r_used <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // advance the read pointer unless the result path is blocked
                    if (!w_stall) begin
                        r_ev   <= w_issue;
                        r_eidx <= r_ridx[SW-1:0];
                        if (w_issue) begin
                            r_ridx <= r_ridx + 1'b1;
                        end
                    end
                    // hold the newest due slot; pass the earlier one on
                    if (w_hit && !w_stall) begin
                        if (r_hold_v) begin
                            r_out.slot    <= r_hold_slot;
                            r_out.status  <= ptts_pkg::STS_OK;
                            r_out.last    <= 1'b0;
                        end
                        r_hold_v    <= 1'b1;
                        r_hold_slot <= 4'(r_eidx);
                        r_hold_sts  <= ptts_pkg::STS_OK;
                        r_cnt       <= r_cnt + 1'b1;
                        if (w_rdata.period == '0) begin
                            r_used[r_eidx] <= 1'b0;
                        end
                    end
                    if (w_scan_end) begin
                        if (w_disp) begin
                            if (!r_hold_v) begin
                                r_hold_slot <= 4'd0;
                                r_hold_sts  <= ptts_pkg::STS_NONE;
                            end
                            r_state <= ST_FLUSH;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ADD: begin
                    // look for the lowest free slot while the divider runs
                    if (!r_found && (r_ridx != IDX_END)) begin
                        if (!r_used[r_ridx[SW-1:0]]) begin
                            r_found    <= 1'b1;
                            r_add_slot <= r_ridx[SW-1:0];
                        end else begin
                            r_ridx <= r_ridx + 1'b1;
                        end
                    end
                    if (w_add_done) begin
                        if (r_found) begin
                            r_used[r_add_slot] <= 1'b1;
                            r_hold_slot        <= 4'(r_add_slot);
                            r_hold_sts         <= ptts_pkg::STS_OK;
                        end else begin
                            r_hold_slot <= 4'd0;
                            r_hold_sts  <= ptts_pkg::STS_FULL;
                        end
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    // send the final result of this request
                    if (w_out_free) begin
                        r_out.slot   <= r_hold_slot;
                        r_out.status <= r_hold_sts;
                        r_out.last   <= 1'b1;
                        r_hold_v     <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // keep the output valid until taken, reload it when a result moves in
            r_out_v <= w_out_load || (r_out_v && !o_rsp.ready);
        end
    end

    assign o_rsp.valid = r_out_v;
    assign o_rsp.data  = r_out;

    `ASSERT_CLK(a_no_rw_clash, i_clk, i_rst_n,
        (w_we && w_rd_en) |-> (w_waddr != w_raddr), "read and write hit the same slot")
    `ASSERT_CLK(a_idle_empty_hold, i_clk, i_rst_n,
        (r_state == ST_IDLE) |-> !r_hold_v, "held result left over in idle")
    `ASSERT_CLK(a_disp_cap, i_clk, i_rst_n,
        r_cnt <= ptts_pkg::DISP_CAP, "dispatch count past cap")
    `ASSERT_CLK(a_stall_holds_ptr, i_clk, i_rst_n,
        w_stall |=> $stable(r_ridx), "read pointer moved during stall")
    `ASSERT_NEVER(a_eval_outside_scan, i_clk, i_rst_n,
        r_ev && (r_state != ST_SCAN), "slot evaluation outside a scan")

endmodule
